@@ hdl/dfqc_pkg.sv @@
package dfqc_pkg;

   localparam int FRAME_WIDTH  = 512;
   localparam int FRAME_HEIGHT = 424;

   localparam int COL_W     = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
   localparam int ROW_W     = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
   localparam int POS_CMP_W = 13;

   localparam int DEPTH_W    = 16;
   localparam int TALLY_W    = 18;
   localparam int LEAST_W    = 12;
   localparam int ROI_X_W    = 10;
   localparam int ROI_Y_W    = 9;
   localparam int LIMIT_W    = 16;
   localparam int AREA_W     = ROI_X_W + ROI_Y_W;
   localparam int PROD_W     = LIMIT_W + AREA_W;
   localparam int Q16_SHIFT  = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DEPTH_W-1:0] NEAR_LIMIT    = 16'd600;
   localparam logic [DEPTH_W-1:0] FAR_LIMIT     = 16'd1300;
   localparam logic [DEPTH_W-1:0] MISSING_VALUE = 16'd0;
   localparam logic [LEAST_W-1:0] LEAST_START   = 12'd4000;
   localparam logic [TALLY_W-1:0] TALLY_MAX     = {TALLY_W{1'b1}};

   localparam logic [ROI_X_W-1:0] ROI_X_START_RST = 10'd153;
   localparam logic [ROI_X_W-1:0] ROI_X_END_RST   = 10'd358;
   localparam logic [ROI_Y_W-1:0] ROI_Y_START_RST = 9'd84;
   localparam logic [ROI_Y_W-1:0] ROI_Y_END_RST   = 9'd339;
   localparam logic [LIMIT_W-1:0] MISSING_LIM_RST = 16'd39322;
   localparam logic [LIMIT_W-1:0] NEAR_LIM_RST    = 16'd6554;
   localparam logic [LIMIT_W-1:0] NOTFAR_LIM_RST  = 16'd19661;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROI_X_START = 3'd0,
      CSR_ROI_X_END   = 3'd1,
      CSR_ROI_Y_START = 3'd2,
      CSR_ROI_Y_END   = 3'd3,
      CSR_MISSING_LIM = 3'd4,
      CSR_NEAR_LIM    = 3'd5,
      CSR_NOTFAR_LIM  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      VERDICT_GOOD = 2'd0,
      VERDICT_NEAR = 2'd1,
      VERDICT_FAR  = 2'd2
   } verdict_type;

   typedef enum logic [2:0] {
      BK_RUN,
      BK_AREA,
      BK_MUL_MISS,
      BK_MUL_NEAR,
      BK_MUL_FAR,
      BK_DONE
   } back_state_type;

   typedef struct packed {
      logic [ROI_X_W-1:0] roi_x_start;
      logic [ROI_X_W-1:0] roi_x_end;
      logic [ROI_Y_W-1:0] roi_y_start;
      logic [ROI_Y_W-1:0] roi_y_end;
      logic [LIMIT_W-1:0] missing_lim;
      logic [LIMIT_W-1:0] near_lim;
      logic [LIMIT_W-1:0] notfar_lim;
   } cfg_type;

   typedef struct packed {
      logic               missing;
      logic               valid;
      logic               near;
      logic               notfar;
      logic [DEPTH_W-1:0] depth;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [ROI_X_W-1:0] clip_x(input logic [ROI_X_W-1:0] x_end);
      logic [ROI_X_W-1:0] res;
      if (POS_CMP_W'(x_end) > POS_CMP_W'(FRAME_WIDTH)) begin
         res = ROI_X_W'(FRAME_WIDTH);
      end else begin
         res = x_end;
      end
      return res;
   endfunction

   function automatic logic [ROI_Y_W-1:0] clip_y(input logic [ROI_Y_W-1:0] y_end);
      logic [ROI_Y_W-1:0] res;
      if (POS_CMP_W'(y_end) > POS_CMP_W'(FRAME_HEIGHT)) begin
         res = ROI_Y_W'(FRAME_HEIGHT);
      end else begin
         res = y_end;
      end
      return res;
   endfunction

endpackage

@@ hdl/dfqc_if.sv @@
interface dfqc_req_if;
   logic                           valid;
   logic                           ready;
   logic [dfqc_pkg::DEPTH_W-1:0]   depth;
   logic                           frame_end;

   modport source(output valid, depth, frame_end, input ready);
   modport sink(input valid, depth, frame_end, output ready);
endinterface

interface dfqc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [1:0]                     verdict;
   logic [dfqc_pkg::TALLY_W-1:0]   missing_count;
   logic [dfqc_pkg::TALLY_W-1:0]   near_count;
   logic [dfqc_pkg::TALLY_W-1:0]   notfar_count;
   logic [dfqc_pkg::LEAST_W-1:0]   least_depth;

   modport source(output valid, verdict, missing_count, near_count, notfar_count,
                  least_depth, input ready);
   modport sink(input valid, verdict, missing_count, near_count, notfar_count,
                least_depth, output ready);
endinterface

@@ hdl/depth_frame_quality_check.sv @@
// Checks one depth frame, fed one pixel per req beat in raster order with frame_end on
// the last pixel, against a rectangle and three Q0.16 fraction limits set over the csr
// port, and gives one rsp beat per frame with the verdict, the missing, near and
// not-far counts and the least valid depth. Pixels are taken at one per cycle while
// the queue has room; the front classifies each pixel and hands it through a
// four-entry queue to the back, which keeps the tallies. On the frame end pixel the
// back works out the area, then the three limit-times-area products through one
// shared multiplier, and waits for a free rsp slot, so the queue absorbs the first
// pixels of the next frame and req ready drops only once it fills.
module depth_frame_quality_check (
   input  logic                               clock,
   input  logic                               reset,
   dfqc_req_if.sink                           req_chan,
   dfqc_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [dfqc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dfqc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   dfqc_pkg::cfg_type          cfg_ff, cfg_in;
   dfqc_pkg::entry_type        push_entry;
   dfqc_pkg::entry_type        head;
   dfqc_pkg::queue_status_type q_status;
   logic                       push;
   logic                       pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            dfqc_pkg::CSR_ROI_X_START:
               cfg_in.roi_x_start = csr_wdata[dfqc_pkg::ROI_X_W-1:0];
            dfqc_pkg::CSR_ROI_X_END:
               cfg_in.roi_x_end = csr_wdata[dfqc_pkg::ROI_X_W-1:0];
            dfqc_pkg::CSR_ROI_Y_START:
               cfg_in.roi_y_start = csr_wdata[dfqc_pkg::ROI_Y_W-1:0];
            dfqc_pkg::CSR_ROI_Y_END:
               cfg_in.roi_y_end = csr_wdata[dfqc_pkg::ROI_Y_W-1:0];
            dfqc_pkg::CSR_MISSING_LIM:
               cfg_in.missing_lim = csr_wdata[dfqc_pkg::LIMIT_W-1:0];
            dfqc_pkg::CSR_NEAR_LIM:
               cfg_in.near_lim = csr_wdata[dfqc_pkg::LIMIT_W-1:0];
            dfqc_pkg::CSR_NOTFAR_LIM:
               cfg_in.notfar_lim = csr_wdata[dfqc_pkg::LIMIT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roi_x_start <= dfqc_pkg::ROI_X_START_RST;
         cfg_ff.roi_x_end   <= dfqc_pkg::ROI_X_END_RST;
         cfg_ff.roi_y_start <= dfqc_pkg::ROI_Y_START_RST;
         cfg_ff.roi_y_end   <= dfqc_pkg::ROI_Y_END_RST;
         cfg_ff.missing_lim <= dfqc_pkg::MISSING_LIM_RST;
         cfg_ff.near_lim    <= dfqc_pkg::NEAR_LIM_RST;
         cfg_ff.notfar_lim  <= dfqc_pkg::NOTFAR_LIM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dfqc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   dfqc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   dfqc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("pixel pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pixel popped from empty queue");

   a_least_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.least_depth <= dfqc_pkg::LEAST_START)
      else $error("least depth above start value");

   a_near_in_notfar: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.near_count <= rsp_chan.notfar_count)
      else $error("near count exceeds not-far count");

endmodule

@@ hdl/dfqc_front.sv @@
module dfqc_front (
   input  logic                         clock,
   input  logic                         reset,
   input  dfqc_pkg::cfg_type            cfg,
   dfqc_req_if.sink                     req_chan,
   input  dfqc_pkg::queue_status_type   q_status,
   output logic                         push,
   output dfqc_pkg::entry_type          push_entry
);

   logic [dfqc_pkg::COL_W-1:0] col_ff, col_in;
   logic [dfqc_pkg::ROW_W-1:0] row_ff, row_in;
   logic [dfqc_pkg::ROI_X_W-1:0] x_end;
   logic [dfqc_pkg::ROI_Y_W-1:0] y_end;
   logic in_roi;
   logic is_missing;

   assign req_chan.ready = !q_status.full;
   assign push = req_chan.valid && req_chan.ready;

   assign x_end = dfqc_pkg::clip_x(cfg.roi_x_end);
   assign y_end = dfqc_pkg::clip_y(cfg.roi_y_end);

   assign in_roi =
      (dfqc_pkg::POS_CMP_W'(col_ff) >= dfqc_pkg::POS_CMP_W'(cfg.roi_x_start)) &&
      (dfqc_pkg::POS_CMP_W'(col_ff) <  dfqc_pkg::POS_CMP_W'(x_end)) &&
      (dfqc_pkg::POS_CMP_W'(row_ff) >= dfqc_pkg::POS_CMP_W'(cfg.roi_y_start)) &&
      (dfqc_pkg::POS_CMP_W'(row_ff) <  dfqc_pkg::POS_CMP_W'(y_end));

   assign is_missing = (req_chan.depth == dfqc_pkg::MISSING_VALUE);

   always_comb begin
      push_entry.missing = in_roi && is_missing;
      push_entry.valid   = in_roi && !is_missing;
      push_entry.near    = in_roi && !is_missing && (req_chan.depth < dfqc_pkg::NEAR_LIMIT);
      push_entry.notfar  = in_roi && !is_missing && (req_chan.depth < dfqc_pkg::FAR_LIMIT);
      push_entry.depth   = req_chan.depth;
      push_entry.last    = req_chan.frame_end;
   end

   // raster position, cleared by the frame end beat
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (req_chan.frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (col_ff == dfqc_pkg::COL_W'(dfqc_pkg::FRAME_WIDTH - 1)) begin
            col_in = '0;
            if (row_ff == dfqc_pkg::ROW_W'(dfqc_pkg::FRAME_HEIGHT - 1)) begin
               row_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

@@ hdl/dfqc_queue.sv @@
module dfqc_queue (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  dfqc_pkg::entry_type          push_entry,
   input  logic                         pop,
   output dfqc_pkg::entry_type          head,
   output dfqc_pkg::queue_status_type   status
);

   dfqc_pkg::entry_type slot_ff [dfqc_pkg::QUEUE_DEPTH];
   logic [dfqc_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [dfqc_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dfqc_pkg::QCNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == dfqc_pkg::QCNT_W'(dfqc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/dfqc_back.sv @@
module dfqc_back (
   input  logic                         clock,
   input  logic                         reset,
   input  dfqc_pkg::cfg_type            cfg,
   input  dfqc_pkg::entry_type          head,
   input  dfqc_pkg::queue_status_type   q_status,
   output logic                         pop,
   dfqc_rsp_if.source                   rsp_chan
);

   dfqc_pkg::back_state_type state_ff, state_in;

   logic [dfqc_pkg::TALLY_W-1:0] missing_ff, missing_in;
   logic [dfqc_pkg::TALLY_W-1:0] near_ff, near_in;
   logic [dfqc_pkg::TALLY_W-1:0] notfar_ff, notfar_in;
   logic [dfqc_pkg::LEAST_W-1:0] least_ff, least_in;

   logic [dfqc_pkg::AREA_W-1:0] area_ff, area_in;
   logic [dfqc_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic miss_over_ff, miss_over_in;
   logic near_over_ff, near_over_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [1:0]                   verdict_ff, verdict_in;
   logic [dfqc_pkg::TALLY_W-1:0] out_missing_ff, out_near_ff, out_notfar_ff;
   logic [dfqc_pkg::LEAST_W-1:0] out_least_ff;

   logic [dfqc_pkg::ROI_X_W-1:0] x_end, width;
   logic [dfqc_pkg::ROI_Y_W-1:0] y_end, height;
   logic [dfqc_pkg::LIMIT_W-1:0] mul_lim;
   logic [dfqc_pkg::PROD_W-1:0]  mul_prod;
   logic [dfqc_pkg::PROD_W-1:0]  missing_scaled, near_scaled, notfar_scaled;
   logic out_free;
   logic load;

   assign x_end  = dfqc_pkg::clip_x(cfg.roi_x_end);
   assign y_end  = dfqc_pkg::clip_y(cfg.roi_y_end);
   assign width  = (x_end > cfg.roi_x_start) ? x_end - cfg.roi_x_start : '0;
   assign height = (y_end > cfg.roi_y_start) ? y_end - cfg.roi_y_start : '0;

   assign missing_scaled = dfqc_pkg::PROD_W'(missing_ff) << dfqc_pkg::Q16_SHIFT;
   assign near_scaled    = dfqc_pkg::PROD_W'(near_ff) << dfqc_pkg::Q16_SHIFT;
   assign notfar_scaled  = dfqc_pkg::PROD_W'(notfar_ff) << dfqc_pkg::Q16_SHIFT;

   // one shared limit times area multiplier
   always_comb begin
      unique case (state_ff)
         dfqc_pkg::BK_MUL_NEAR: mul_lim = cfg.near_lim;
         dfqc_pkg::BK_MUL_FAR:  mul_lim = cfg.notfar_lim;
         default:               mul_lim = cfg.missing_lim;
      endcase
   end
   assign mul_prod = dfqc_pkg::PROD_W'(mul_lim) * dfqc_pkg::PROD_W'(area_ff);

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign pop  = (state_ff == dfqc_pkg::BK_RUN) && !q_status.empty;
   assign load = (state_ff == dfqc_pkg::BK_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfqc_pkg::BK_RUN: begin
            if (pop && head.last) begin
               state_in = dfqc_pkg::BK_AREA;
            end
         end
         dfqc_pkg::BK_AREA:     state_in = dfqc_pkg::BK_MUL_MISS;
         dfqc_pkg::BK_MUL_MISS: state_in = dfqc_pkg::BK_MUL_NEAR;
         dfqc_pkg::BK_MUL_NEAR: state_in = dfqc_pkg::BK_MUL_FAR;
         dfqc_pkg::BK_MUL_FAR:  state_in = dfqc_pkg::BK_DONE;
         dfqc_pkg::BK_DONE: begin
            if (out_free) begin
               state_in = dfqc_pkg::BK_RUN;
            end
         end
         default: state_in = dfqc_pkg::BK_RUN;
      endcase
   end

   always_comb begin
      missing_in   = missing_ff;
      near_in      = near_ff;
      notfar_in    = notfar_ff;
      least_in     = least_ff;
      area_in      = area_ff;
      prod_in      = prod_ff;
      miss_over_in = miss_over_ff;
      near_over_in = near_over_ff;
      verdict_in   = dfqc_pkg::VERDICT_GOOD;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         dfqc_pkg::BK_RUN: begin
            if (pop) begin
               if (head.missing && missing_ff != dfqc_pkg::TALLY_MAX) begin
                  missing_in = missing_ff + 1'b1;
               end
               if (head.near && near_ff != dfqc_pkg::TALLY_MAX) begin
                  near_in = near_ff + 1'b1;
               end
               if (head.notfar && notfar_ff != dfqc_pkg::TALLY_MAX) begin
                  notfar_in = notfar_ff + 1'b1;
               end
               if (head.valid && head.depth < dfqc_pkg::DEPTH_W'(least_ff)) begin
                  least_in = head.depth[dfqc_pkg::LEAST_W-1:0];
               end
            end
         end
         dfqc_pkg::BK_AREA: begin
            area_in = dfqc_pkg::AREA_W'(width) * dfqc_pkg::AREA_W'(height);
         end
         dfqc_pkg::BK_MUL_MISS: begin
            prod_in = mul_prod;
         end
         dfqc_pkg::BK_MUL_NEAR: begin
            miss_over_in = missing_scaled > prod_ff;
            prod_in      = mul_prod;
         end
         dfqc_pkg::BK_MUL_FAR: begin
            near_over_in = near_scaled > prod_ff;
            prod_in      = mul_prod;
         end
         dfqc_pkg::BK_DONE: begin
            if (area_ff == '0) begin
               verdict_in = dfqc_pkg::VERDICT_GOOD;
            end else if (miss_over_ff || near_over_ff) begin
               verdict_in = dfqc_pkg::VERDICT_NEAR;
            end else if (notfar_scaled < prod_ff) begin
               verdict_in = dfqc_pkg::VERDICT_FAR;
            end else begin
               verdict_in = dfqc_pkg::VERDICT_GOOD;
            end
            if (load) begin
               rsp_valid_in = 1'b1;
               missing_in   = '0;
               near_in      = '0;
               notfar_in    = '0;
               least_in     = dfqc_pkg::LEAST_START;
            end
         end
         default: begin
            verdict_in = dfqc_pkg::VERDICT_GOOD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dfqc_pkg::BK_RUN;
         missing_ff   <= '0;
         near_ff      <= '0;
         notfar_ff    <= '0;
         least_ff     <= dfqc_pkg::LEAST_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         missing_ff   <= missing_in;
         near_ff      <= near_in;
         notfar_ff    <= notfar_in;
         least_ff     <= least_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      area_ff      <= area_in;
      prod_ff      <= prod_in;
      miss_over_ff <= miss_over_in;
      near_over_ff <= near_over_in;
      if (load) begin
         verdict_ff     <= verdict_in;
         out_missing_ff <= missing_ff;
         out_near_ff    <= near_ff;
         out_notfar_ff  <= notfar_ff;
         out_least_ff   <= least_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.verdict       = verdict_ff;
   assign rsp_chan.missing_count = out_missing_ff;
   assign rsp_chan.near_count    = out_near_ff;
   assign rsp_chan.notfar_count  = out_notfar_ff;
   assign rsp_chan.least_depth   = out_least_ff;

endmodule

@@ verif/dfqc_frame_checker.sv @@
module dfqc_frame_checker (
   input  logic                            clock,
   input  logic                            reset,
   dfqc_req_if                             req_mon,
   dfqc_rsp_if                             rsp_mon,
   input  logic                            csr_we,
   input  logic [dfqc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dfqc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              reports_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      dfqc_pkg::verdict_type        verdict;
      logic [dfqc_pkg::TALLY_W-1:0] missing;
      logic [dfqc_pkg::TALLY_W-1:0] near;
      logic [dfqc_pkg::TALLY_W-1:0] notfar;
      logic [dfqc_pkg::LEAST_W-1:0] least;
   } frame_report_type;

   dfqc_pkg::cfg_type            regs;
   int unsigned                  col;
   int unsigned                  row;
   logic [dfqc_pkg::TALLY_W-1:0] missing_tally;
   logic [dfqc_pkg::TALLY_W-1:0] near_tally;
   logic [dfqc_pkg::TALLY_W-1:0] notfar_tally;
   logic [dfqc_pkg::LEAST_W-1:0] least_depth;
   frame_report_type             due_reports [$];
   int                           error_total = 0;

   assign mismatches = error_total;

   function automatic void restart_frame();
      col = 0;
      row = 0;
      missing_tally = '0;
      near_tally = '0;
      notfar_tally = '0;
      least_depth = dfqc_pkg::LEAST_START;
   endfunction

   function automatic void compare_field(input string field, input longint unsigned want,
                                         input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         error_total++;
      end
   endfunction

   // tally one pixel; on the frame end pixel queue the frame report
   function automatic void add_pixel(input logic [dfqc_pkg::DEPTH_W-1:0] depth,
                                     input logic last);
      longint unsigned  x_lim;
      longint unsigned  y_lim;
      longint unsigned  w;
      longint unsigned  h;
      longint unsigned  area;
      logic             in_rect;
      frame_report_type rep;
      x_lim = (regs.roi_x_end > dfqc_pkg::FRAME_WIDTH) ? dfqc_pkg::FRAME_WIDTH :
              regs.roi_x_end;
      y_lim = (regs.roi_y_end > dfqc_pkg::FRAME_HEIGHT) ? dfqc_pkg::FRAME_HEIGHT :
              regs.roi_y_end;
      in_rect = col >= regs.roi_x_start && col < x_lim &&
                row >= regs.roi_y_start && row < y_lim;
      if (in_rect) begin
         if (depth == dfqc_pkg::MISSING_VALUE) begin
            if (missing_tally != dfqc_pkg::TALLY_MAX) missing_tally++;
         end else begin
            if (depth < least_depth) least_depth = depth[dfqc_pkg::LEAST_W-1:0];
            if (depth < dfqc_pkg::NEAR_LIMIT && near_tally != dfqc_pkg::TALLY_MAX)
               near_tally++;
            if (depth < dfqc_pkg::FAR_LIMIT && notfar_tally != dfqc_pkg::TALLY_MAX)
               notfar_tally++;
         end
      end
      if (!last) begin
         col++;
         if (col >= dfqc_pkg::FRAME_WIDTH) begin
            col = 0;
            row++;
            if (row >= dfqc_pkg::FRAME_HEIGHT) row = 0;
         end
      end else begin
         w = (x_lim > regs.roi_x_start) ? x_lim - regs.roi_x_start : 0;
         h = (y_lim > regs.roi_y_start) ? y_lim - regs.roi_y_start : 0;
         area = w * h;
         rep.verdict = dfqc_pkg::VERDICT_GOOD;
         if (area != 0) begin
            if ({missing_tally, 16'h0} > regs.missing_lim * area ||
                {near_tally, 16'h0} > regs.near_lim * area) begin
               rep.verdict = dfqc_pkg::VERDICT_NEAR;
            end else if ({notfar_tally, 16'h0} < regs.notfar_lim * area) begin
               rep.verdict = dfqc_pkg::VERDICT_FAR;
            end
         end
         rep.missing = missing_tally;
         rep.near = near_tally;
         rep.notfar = notfar_tally;
         rep.least = least_depth;
         due_reports.push_back(rep);
         restart_frame();
      end
   endfunction

   always @(posedge clock) begin
      frame_report_type want;
      if (reset) begin
         regs.roi_x_start = dfqc_pkg::ROI_X_START_RST;
         regs.roi_x_end = dfqc_pkg::ROI_X_END_RST;
         regs.roi_y_start = dfqc_pkg::ROI_Y_START_RST;
         regs.roi_y_end = dfqc_pkg::ROI_Y_END_RST;
         regs.missing_lim = dfqc_pkg::MISSING_LIM_RST;
         regs.near_lim = dfqc_pkg::NEAR_LIM_RST;
         regs.notfar_lim = dfqc_pkg::NOTFAR_LIM_RST;
         restart_frame();
         due_reports.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               dfqc_pkg::CSR_ROI_X_START:
                  regs.roi_x_start = csr_wdata[dfqc_pkg::ROI_X_W-1:0];
               dfqc_pkg::CSR_ROI_X_END:
                  regs.roi_x_end = csr_wdata[dfqc_pkg::ROI_X_W-1:0];
               dfqc_pkg::CSR_ROI_Y_START:
                  regs.roi_y_start = csr_wdata[dfqc_pkg::ROI_Y_W-1:0];
               dfqc_pkg::CSR_ROI_Y_END:
                  regs.roi_y_end = csr_wdata[dfqc_pkg::ROI_Y_W-1:0];
               dfqc_pkg::CSR_MISSING_LIM:
                  regs.missing_lim = csr_wdata[dfqc_pkg::LIMIT_W-1:0];
               dfqc_pkg::CSR_NEAR_LIM:
                  regs.near_lim = csr_wdata[dfqc_pkg::LIMIT_W-1:0];
               dfqc_pkg::CSR_NOTFAR_LIM:
                  regs.notfar_lim = csr_wdata[dfqc_pkg::LIMIT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_reports.size() == 0) begin
               $error("frame report beat with no frame end pending");
               error_total++;
            end else begin
               want = due_reports.pop_front();
               compare_field("verdict", want.verdict, rsp_mon.verdict);
               compare_field("missing_count", want.missing, rsp_mon.missing_count);
               compare_field("near_count", want.near, rsp_mon.near_count);
               compare_field("notfar_count", want.notfar, rsp_mon.notfar_count);
               compare_field("least_depth", want.least, rsp_mon.least_depth);
            end
         end
         if (req_mon.valid && req_mon.ready) add_pixel(req_mon.depth, req_mon.frame_end);
      end
      reports_pending <= due_reports.size();
   end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic                            clock;
   logic                            reset;
   logic                            csr_we;
   logic [dfqc_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [dfqc_pkg::CSR_DATA_W-1:0] csr_wdata;
   int                              tx_idle_pct;
   int                              rx_idle_pct;
   logic                            rx_hold;
   logic                            hold_go;
   int                              mismatches;
   int                              reports_pending;
   int                              pixels_sent;
   int                              frame_ends_sent;
   int                              settings_loaded;

   dfqc_req_if req_if();
   dfqc_rsp_if rsp_if();

   depth_frame_quality_check dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dfqc_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .reports_pending (reports_pending)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long receiver stall so frame reports back up and req ready drops
   initial begin
      rx_hold = 1'b0;
      wait (hold_go);
      rx_hold <= 1'b1;
      repeat (300) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      #5_000_000;
      $display("depth_frame_quality_check: mismatch");
      $finish;
   end

   task automatic send_pixel(input logic [dfqc_pkg::DEPTH_W-1:0] depth, input logic last);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.depth <= depth;
      req_if.frame_end <= last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pixels_sent++;
      if (last) frame_ends_sent++;
   endtask

   function automatic logic [dfqc_pkg::DEPTH_W-1:0] pick_depth();
      case ($urandom_range(9))
         0, 1: return dfqc_pkg::MISSING_VALUE;
         2: return dfqc_pkg::DEPTH_W'($urandom_range(int'(dfqc_pkg::NEAR_LIMIT) - 1, 1));
         3: return dfqc_pkg::DEPTH_W'($urandom_range(int'(dfqc_pkg::FAR_LIMIT) - 1, 1));
         4: return dfqc_pkg::DEPTH_W'($urandom_range(int'(dfqc_pkg::LEAST_START) - 1,
                                                     int'(dfqc_pkg::FAR_LIMIT)));
         5: return dfqc_pkg::DEPTH_W'($urandom_range(65535, int'(dfqc_pkg::LEAST_START)));
         6: begin
            // values on either side of each threshold
            case ($urandom_range(4))
               0: return dfqc_pkg::NEAR_LIMIT - 16'd1 +
                         dfqc_pkg::DEPTH_W'($urandom_range(1));
               1: return dfqc_pkg::FAR_LIMIT - 16'd1 +
                         dfqc_pkg::DEPTH_W'($urandom_range(1));
               2: return dfqc_pkg::DEPTH_W'(dfqc_pkg::LEAST_START) - 16'd1 +
                         dfqc_pkg::DEPTH_W'($urandom_range(1));
               3: return 16'd4095 + dfqc_pkg::DEPTH_W'($urandom_range(1));
               default: return $urandom_range(1) ? 16'hFFFF : 16'd1;
            endcase
         end
         default: return dfqc_pkg::DEPTH_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic int frame_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 2) return $urandom_range(1100, 513);
      if (roll < 12) return $urandom_range(120, 25);
      return $urandom_range(24, 1);
   endfunction

   task automatic send_frame(input int len, input bit closed);
      for (int i = 0; i < len; i++) send_pixel(pick_depth(), closed && i == len - 1);
   endtask

   function automatic logic [dfqc_pkg::LIMIT_W-1:0] pick_limit();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return dfqc_pkg::LIMIT_W'(1) << $urandom_range(15, 8);
         default: return dfqc_pkg::LIMIT_W'($urandom_range(65535));
      endcase
   endfunction

   function automatic dfqc_pkg::cfg_type make_settings(input int unsigned xs, xe, ys, ye,
                                                       input int unsigned miss, near,
                                                       notfar);
      dfqc_pkg::cfg_type c;
      c.roi_x_start = dfqc_pkg::ROI_X_W'(xs);
      c.roi_x_end = dfqc_pkg::ROI_X_W'(xe);
      c.roi_y_start = dfqc_pkg::ROI_Y_W'(ys);
      c.roi_y_end = dfqc_pkg::ROI_Y_W'(ye);
      c.missing_lim = dfqc_pkg::LIMIT_W'(miss);
      c.near_lim = dfqc_pkg::LIMIT_W'(near);
      c.notfar_lim = dfqc_pkg::LIMIT_W'(notfar);
      return c;
   endfunction

   function automatic dfqc_pkg::cfg_type random_settings();
      dfqc_pkg::cfg_type c;
      c.roi_x_start = dfqc_pkg::ROI_X_W'($urandom_range(12));
      c.roi_x_end = ($urandom_range(7) == 0) ? dfqc_pkg::ROI_X_W'(dfqc_pkg::FRAME_WIDTH) :
                    dfqc_pkg::ROI_X_W'($urandom_range(32));
      c.roi_y_start = dfqc_pkg::ROI_Y_W'($urandom_range(1));
      c.roi_y_end = ($urandom_range(5) == 0) ? dfqc_pkg::ROI_Y_W'(dfqc_pkg::FRAME_HEIGHT) :
                    dfqc_pkg::ROI_Y_W'($urandom_range(3));
      c.missing_lim = pick_limit();
      c.near_lim = pick_limit();
      c.notfar_lim = pick_limit();
      return c;
   endfunction

   task automatic put_reg(input dfqc_pkg::csr_index_type idx,
                          input logic [dfqc_pkg::CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input dfqc_pkg::cfg_type c);
      put_reg(dfqc_pkg::CSR_ROI_X_START, dfqc_pkg::CSR_DATA_W'(c.roi_x_start));
      put_reg(dfqc_pkg::CSR_ROI_X_END, dfqc_pkg::CSR_DATA_W'(c.roi_x_end));
      put_reg(dfqc_pkg::CSR_ROI_Y_START, dfqc_pkg::CSR_DATA_W'(c.roi_y_start));
      put_reg(dfqc_pkg::CSR_ROI_Y_END, dfqc_pkg::CSR_DATA_W'(c.roi_y_end));
      put_reg(dfqc_pkg::CSR_MISSING_LIM, c.missing_lim);
      put_reg(dfqc_pkg::CSR_NEAR_LIM, c.near_lim);
      put_reg(dfqc_pkg::CSR_NOTFAR_LIM, c.notfar_lim);
      csr_we <= 1'b0;
      settings_loaded++;
   endtask

   task automatic wait_reports();
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
   endtask

   // stop sending and let the block empty before touching registers
   task automatic settle();
      req_if.valid <= 1'b0;
      wait_reports();
      repeat (20) @(posedge clock);
   endtask

   initial begin
      dfqc_pkg::cfg_type s;
      int                budget;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = dfqc_pkg::CSR_ROI_X_START;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.depth = '0;
      req_if.frame_end = 1'b0;
      tx_idle_pct = 24;
      rx_idle_pct = 78;
      hold_go = 1'b0;
      pixels_sent = 0;
      frame_ends_sent = 0;
      settings_loaded = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset rectangle lies far from a one pixel frame
      send_pixel(16'd0, 1'b1);

      // four pixel rectangle, fractions landing on the limits
      settle();
      load_settings(make_settings(0, 4, 0, 1, 16384, 16384, 32768));
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd599, 1'b0);
      send_pixel(16'd1300, 1'b0);
      send_pixel(16'd65535, 1'b1);
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd4000, 1'b0);
      send_pixel(16'd3999, 1'b1);
      send_pixel(16'd600, 1'b0);
      send_pixel(16'd1299, 1'b0);
      send_pixel(16'd4095, 1'b0);
      send_pixel(16'd1, 1'b1);
      // short frame still uses the full area
      send_pixel(16'd700, 1'b1);
      // last pixel falls outside the rectangle
      send_pixel(16'd100, 1'b0);
      send_pixel(16'd100, 1'b0);
      send_pixel(16'd100, 1'b0);
      send_pixel(16'd100, 1'b0);
      send_pixel(16'd0, 1'b1);

      // empty rectangle on both axes
      settle();
      load_settings(make_settings(dfqc_pkg::FRAME_WIDTH, 300, dfqc_pkg::FRAME_HEIGHT, 0,
                                  0, 0, 0));
      send_pixel(16'd0, 1'b0);
      send_pixel(16'd5, 1'b1);

      for (int p = 0; p < 6; p++) begin
         settle();
         tx_idle_pct <= (p < 2) ? 24 : (p < 4) ? 78 : 0;
         rx_idle_pct <= (p < 2) ? 78 : (p < 4) ? 24 : 0;
         case (p)
            0: s = make_settings(0, dfqc_pkg::FRAME_WIDTH, 0, dfqc_pkg::FRAME_HEIGHT,
                                 65535, 65535, 65535);
            1: begin
               s = random_settings();
               s.missing_lim = '0;
               s.near_lim = '0;
               s.notfar_lim = '0;
            end
            default: s = random_settings();
         endcase
         load_settings(s);
         if (p == 4) hold_go <= 1'b1;
         budget = pixels_sent + 150;
         for (int f = 0; pixels_sent < budget; f++) begin
            if (p == 2 && f == 4) begin
               req_if.valid <= 1'b0;
               wait_reports();
            end
            send_frame(frame_length(), $urandom_range(19) != 0);
         end
      end

      // rectangle past the frame edges; one frame long enough to wrap the column
      settle();
      load_settings(make_settings(0, 1023, 0, 511, 65535, 65535, 65535));
      send_frame(600, 1'b1);

      req_if.valid <= 1'b0;
      wait_reports();
      repeat (20) @(posedge clock);
      $display("sent %0d pixels with %0d frame ends across %0d register settings",
               pixels_sent, frame_ends_sent, settings_loaded);
      $display("with idling on both sides, a long report stall and a clipped rectangle");
      if (mismatches == 0) begin
         $display("depth_frame_quality_check: match");
      end else begin
         $display("depth_frame_quality_check: mismatch");
      end
      $finish;
   end

endmodule
